// ----- hw/rtl/vertical_line_page_writer_unit_defines.svh -----
// assertion macros shared by the vertical line page writer rtl
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef VERTICAL_LINE_PAGE_WRITER_UNIT_DEFINES_SVH
`define VERTICAL_LINE_PAGE_WRITER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check a property on every clock edge outside reset
`define VLPW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check a property on every clock edge, reset included
`define VLPW_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VLPW_ASSERT(label, clk, rst, prop, msg)
`define VLPW_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- hw/rtl/vlpw_pkg.sv -----
// types and constants of the vertical line page writer
// no dependencies
`timescale 1ns / 1ps

package vlpw_pkg;

   // display geometry
   localparam int ROWS         = 64;
   localparam int HALF_COLUMNS = 64;

   // lcd controller command codes
   localparam logic [7:0] CMD_SET_COLUMN = 8'h40;
   localparam logic [7:0] CMD_SET_PAGE   = 8'hB8;

   // write sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COLUMN,
      ST_PAGE,
      ST_DATA
   } state_type;

endpackage

// ----- hw/rtl/vertical_line_page_writer_unit.sv -----
// vertical line page writer: one segment request in, lcd bus writes out
// depends on vlpw_pkg and vertical_line_page_writer_unit_defines.svh
// the first write beat is offered in the cycle after the request beat is taken
// write beats: 3 per touched 8-row page (3..24), one per cycle without stall;
//    the next request is taken only once the sequencer is back in idle
// the writes are issued by the page sequencer, one per cycle unless rsp_stall
// reset (synchronous, active high) returns the sequencer to idle
`timescale 1ns / 1ps
`include "vertical_line_page_writer_unit_defines.svh"

module vertical_line_page_writer_unit (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [6:0] req_column,
   input  logic [5:0] req_row_a,
   input  logic [5:0] req_row_b,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_right_half,
   output logic       rsp_is_data,
   output logic [7:0] rsp_bus_byte,
   output logic       rsp_last
);
   import vlpw_pkg::*;

   localparam logic [8:0] ROW_MAX  = 9'(ROWS - 1);
   localparam logic [7:0] HALF_COL = 8'(HALF_COLUMNS);

   // sequencer state
   state_type  state_ff, state_in;
   logic [2:0] page_ff,  page_in;

   // segment held for the whole write sequence
   logic [5:0] lo_ff,    lo_in;
   logic [5:0] hi_ff,    hi_in;
   logic [5:0] addr_ff,  addr_in;
   logic       right_ff, right_in;

   // request decode
   logic       req_take;
   logic       rsp_take;
   logic [5:0] row_lo;
   logic [5:0] row_hi;
   logic [7:0] col_sub;
   logic       col_right;

   // data byte shift unit
   logic [2:0] first_bit;
   logic [2:0] last_bit;
   logic [7:0] row_mask;
   logic       last_page;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   // put the row ends in order, then clamp them to the display height
   always_comb begin
      logic [5:0] a_ord;
      logic [5:0] b_ord;
      a_ord = (req_row_a > req_row_b) ? req_row_b : req_row_a;
      b_ord = (req_row_a > req_row_b) ? req_row_a : req_row_b;
      row_lo = ({3'b000, a_ord} > ROW_MAX) ? ROW_MAX[5:0] : a_ord;
      row_hi = ({3'b000, b_ord} > ROW_MAX) ? ROW_MAX[5:0] : b_ord;
   end

   // controller select and the column address within that controller
   assign col_right = ({1'b0, req_column} >= HALF_COL);
   assign col_sub   = {1'b0, req_column} - HALF_COL;

   // first and last lit bit of the current page
   assign last_page = (page_ff == hi_ff[5:3]);
   assign first_bit = (page_ff == lo_ff[5:3]) ? lo_ff[2:0] : 3'd0;
   assign last_bit  = last_page ? hi_ff[2:0] : 3'd7;
   assign row_mask  = (8'hFF << first_bit) & (8'hFF >> (3'd7 - last_bit));

   // next state: column, page, data for each page from low to high
   always_comb begin
      state_in = state_ff;
      page_in  = page_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      addr_in  = addr_ff;
      right_in = right_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_COLUMN;
               lo_in    = row_lo;
               hi_in    = row_hi;
               page_in  = row_lo[5:3];
               right_in = col_right;
               addr_in  = col_right ? col_sub[5:0] : req_column[5:0];
            end
         end
         ST_COLUMN: begin
            if (rsp_take) begin
               state_in = ST_PAGE;
            end
         end
         ST_PAGE: begin
            if (rsp_take) begin
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (rsp_take) begin
               if (last_page) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_COLUMN;
                  page_in  = page_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs: one write beat per busy state, all fields from registers
   always_comb begin
      req_stall      = (state_ff != ST_IDLE);
      rsp_valid      = 1'b0;
      rsp_right_half = right_ff;
      rsp_is_data    = 1'b0;
      rsp_bus_byte   = 8'h00;
      rsp_last       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            rsp_valid = 1'b0;
         end
         ST_COLUMN: begin
            rsp_valid    = 1'b1;
            rsp_bus_byte = CMD_SET_COLUMN | {2'b00, addr_ff};
         end
         ST_PAGE: begin
            rsp_valid    = 1'b1;
            rsp_bus_byte = CMD_SET_PAGE | {5'b00000, page_ff};
         end
         ST_DATA: begin
            rsp_valid    = 1'b1;
            rsp_is_data  = 1'b1;
            rsp_bus_byte = row_mask;
            rsp_last     = last_page;
         end
         default: begin
            rsp_valid = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // segment registers, no reset needed
   always_ff @(posedge clock) begin
      page_ff  <= page_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      addr_ff  <= addr_in;
      right_ff <= right_in;
   end

   // a taken request always starts with the set-column write
   `VLPW_ASSERT(a_start_column, clock, reset, req_take |=> (state_ff == ST_COLUMN), "request did not start with set-column")
   // the page walk stays between the segment's bottom and top pages
   `VLPW_ASSERT(a_page_bound, clock, reset, (state_ff != ST_IDLE) |-> (page_ff <= hi_ff[5:3]) && (page_ff >= lo_ff[5:3]), "page outside segment")
   // a taken non-final data write moves on to the next page
   `VLPW_ASSERT(a_page_step, clock, reset, (rsp_take && rsp_is_data && !rsp_last) |=> (state_ff == ST_COLUMN) && (page_ff == $past(page_ff) + 3'd1), "page step lost")
   // the final flag only rides on a data write
   `VLPW_ASSERT(a_last_data, clock, reset, rsp_last |-> rsp_is_data && rsp_valid, "last flag on command write")
   // the data byte is never empty
   `VLPW_ASSERT(a_byte_nonzero, clock, reset, (rsp_valid && rsp_is_data) |-> (rsp_bus_byte != 8'h00), "empty data byte")
   // no response beat while $past(reset) is high
   `VLPW_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_valid, "response beat after reset")

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the vertical line page writer
// depends on vlpw_pkg and vertical_line_page_writer_unit (no other files)
`timescale 1ns / 1ps

module tb_top;
   import vlpw_pkg::*;

   // cycles with no beat on either channel before the run is called hung
   localparam int unsigned HANG_LIMIT = 2000;
   // cycles left to run after the last write beat, well past the block latency
   localparam int unsigned TAIL_CYCLES = 30;
   // chance of an idle cycle on either side, in percent
   localparam int unsigned GAP_PERCENT = 8;

   // one lcd bus write as seen on the response channel
   typedef struct packed {
      logic       right_half;
      logic       is_data;
      logic [7:0] bus_byte;
      logic       last;
   } lcd_write_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [6:0] req_column = '0;
   logic [5:0] req_row_a = '0;
   logic [5:0] req_row_b = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_right_half;
   logic       rsp_is_data;
   logic [7:0] rsp_bus_byte;
   logic       rsp_last;

   // writes predicted for accepted segments, oldest first
   lcd_write_type pending_writes[$];
   int unsigned   mismatch_count = 0;
   int unsigned   quiet_cycles = 0;
   // when low neither side inserts idle cycles
   bit            gaps_on = 1'b1;

   vertical_line_page_writer_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_column     (req_column),
      .req_row_a      (req_row_a),
      .req_row_b      (req_row_b),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_right_half (rsp_right_half),
      .rsp_is_data    (rsp_is_data),
      .rsp_bus_byte   (rsp_bus_byte),
      .rsp_last       (rsp_last)
   );

   always #1 clock = ~clock;

   // random idle decision shared by both sides
   function automatic bit take_gap();
      return gaps_on && ($urandom_range(99) < GAP_PERCENT);
   endfunction

   // row end biased toward page edges, where the byte masks change shape
   function automatic logic [5:0] pick_row();
      logic [5:0] row;
      row = 6'($urandom_range(63));
      if ($urandom_range(3) == 0) begin
         row[2:0] = $urandom_range(1) ? 3'd7 : 3'd0;
      end
      return row;
   endfunction

   // expected write sequence for one segment: three writes per touched page
   function automatic void plan_segment_writes(input logic [6:0] column,
                                               input logic [5:0] row_a,
                                               input logic [5:0] row_b);
      int unsigned   lo_row;
      int unsigned   hi_row;
      int unsigned   first_bit;
      int unsigned   last_bit;
      logic          right;
      logic [5:0]    col_addr;
      lcd_write_type wr;
      // put the ends in order, then clip to the panel height
      lo_row = 32'((row_a > row_b) ? row_b : row_a);
      hi_row = 32'((row_a > row_b) ? row_a : row_b);
      if (hi_row > ROWS - 1) hi_row = ROWS - 1;
      if (lo_row > ROWS - 1) lo_row = ROWS - 1;
      // controller select and its local column address, cut to 6 bits
      right    = (column >= HALF_COLUMNS);
      col_addr = 6'(right ? column - HALF_COLUMNS : column);
      for (int page = lo_row / 8; page <= hi_row / 8; page++) begin
         first_bit = (page == lo_row / 8) ? lo_row % 8 : 0;
         last_bit  = (page == hi_row / 8) ? hi_row % 8 : 7;
         wr.right_half = right;
         wr.is_data    = 1'b0;
         wr.last       = 1'b0;
         wr.bus_byte   = CMD_SET_COLUMN | {2'b00, col_addr};
         pending_writes.push_back(wr);
         wr.bus_byte   = CMD_SET_PAGE | 8'(page & 7);
         pending_writes.push_back(wr);
         wr.is_data    = 1'b1;
         wr.bus_byte   = (8'hFF << first_bit) & (8'hFF >> (7 - last_bit));
         wr.last       = (page == hi_row / 8);
         pending_writes.push_back(wr);
      end
   endfunction

   // offer one segment beat, with random idle cycles ahead of it, and wait
   // for it to be taken; valid is left high so a following beat can follow
   // without a bubble, the caller lowers it when the burst ends
   task automatic send_segment(input logic [6:0] column,
                               input logic [5:0] row_a,
                               input logic [5:0] row_b);
      while (take_gap()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_column <= column;
      req_row_a  <= row_a;
      req_row_b  <= row_b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      plan_segment_writes(column, row_a, row_b);
   endtask

   task automatic send_random_segment();
      send_segment(7'($urandom_range(127)), pick_row(), pick_row());
   endtask

   // drop valid and hold off until every predicted write has shown up
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_writes.size() != 0) @(posedge clock);
   endtask

   task automatic report_field(input string field_name, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field_name, want, got);
         mismatch_count++;
      end
   endtask

   // response side: random stall, and each write beat checked against the
   // oldest prediction
   always @(posedge clock) begin
      lcd_write_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_writes.size() == 0) begin
            $display("%0t: write beat with none expected, expected nothing, got %0b %0b 0x%0h %0b",
                     $time, rsp_right_half, rsp_is_data, rsp_bus_byte, rsp_last);
            mismatch_count++;
         end else begin
            want = pending_writes.pop_front();
            report_field("right_half", want.right_half, rsp_right_half);
            report_field("is_data", want.is_data, rsp_is_data);
            report_field("bus_byte", want.bus_byte, rsp_bus_byte);
            report_field("last", want.last, rsp_last);
         end
      end
      rsp_stall <= take_gap();
   end

   // hang guard: any beat on either channel resets the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= HANG_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   // ends, half boundary, single rows, reversed ends, page edges
   task automatic test_directed_segments();
      send_segment(7'd0, 6'd0, 6'd0);      // top row, left edge
      send_segment(7'd127, 6'd63, 6'd63);  // bottom row, right edge
      send_segment(7'd63, 6'd0, 6'd63);    // full height, last left column
      send_segment(7'd64, 6'd63, 6'd0);    // full height reversed, first right column
      send_segment(7'd10, 6'd5, 6'd5);     // single row mid page
      send_segment(7'd5, 6'd1, 6'd6);      // inside one page
      send_segment(7'd33, 6'd7, 6'd8);     // straddles a page edge
      send_segment(7'd100, 6'd8, 6'd15);   // exactly one whole page
      send_segment(7'd65, 6'd63, 6'd56);   // last page reversed
      send_segment(7'd3, 6'd40, 6'd17);    // reversed, several pages
      send_segment(7'd127, 6'd0, 6'd63);   // full height, right edge
      send_segment(7'd42, 6'd63, 6'd0);    // full height reversed, left half
      send_segment(7'd85, 6'd42, 6'd21);   // alternating bit patterns
      send_segment(7'd64, 6'd0, 6'd0);     // single row, first right column
      send_segment(7'd96, 6'd31, 6'd32);   // middle page edge
      wait_for_drain();
   endtask

   // long stretch with no idle cycles on either side
   task automatic test_back_to_back();
      gaps_on = 1'b0;
      repeat (40) send_random_segment();
      wait_for_drain();
      gaps_on = 1'b1;
   endtask

   // random segments with idle cycles on both sides
   task automatic test_random_gaps();
      repeat (45) send_random_segment();
      wait_for_drain();
   endtask

   // sender holds off mid stream until the writer has emptied out
   task automatic test_pause_for_drain();
      repeat (10) send_random_segment();
      wait_for_drain();
      repeat (10) send_random_segment();
      wait_for_drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_segments();
      test_back_to_back();
      test_random_gaps();
      test_pause_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_writes.size() != 0) begin
         $display("%0t: writes still outstanding, expected 0, got %0d",
                  $time, pending_writes.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
